// ----- sv/tsis_pkg.sv -----
// Shared types and constants for the two-stack insertion sort unit.
package tsis_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_POP,
        ST_HOLD,
        ST_PLACE,
        ST_REFILL,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } tsis_state_t;

endpackage

// ----- sv/tsis_ram.sv -----
// Single-port-write, single-port-read memory with a registered read.
module tsis_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/two_stack_insertion_sort_unit.sv -----
// Top level of the two-stack insertion sort unit.
//
// Input channel (s_*): one signed 32-bit value per item in s_tdata, s_tlast
// marks the final value of a set. Values are pushed onto a main stack held in
// a memory, one item per cycle; pushes beyond STACK_DEPTH are dropped and
// flagged. The item with s_tlast is pushed too and starts the sort.
// The sort pops each main-stack entry and walks a helper stack in a second
// memory, moving larger entries back to the main stack before placing the
// value. Each pop passes through POP, HOLD and PLACE, each move back through
// PLACE and, while helper entries remain, REFILL, and every moved entry is
// popped again. Output channel (m_*): the n values leave in ascending order,
// each read from the helper memory and then passed through an output
// register; m_tlast marks the largest and m_tuser is set on every result of
// a set that lost values to overflow. s_tready is low from the last item
// until the last result is registered. A stall on m_tready holds the output
// register and pauses the drain.
// Reset empties both stacks and clears the overflow flag; memory contents
// are not cleared and need no clearing pass.
module two_stack_insertion_sort_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsis_pkg::DATA_W-1:0]   s_tdata,   // [31:0] sample_value
    input  logic                          s_tlast,   // end_of_set
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsis_pkg::DATA_W-1:0]   m_tdata,   // [31:0] sorted_value
    output logic                          m_tlast,   // final_result
    output logic                          m_tuser    // [0] values_dropped
);

    import tsis_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    tsis_state_t state_reg, state_next;

    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            aux_reg, aux_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     ovf_reg, ovf_next;
    logic signed [DATA_W-1:0] held_reg, held_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic                     m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]        m_data_reg, m_data_next;
    logic                     m_last_reg, m_last_next;
    logic                     m_user_reg, m_user_next;

    logic              main_we, main_re;
    logic [AW-1:0]     main_waddr, main_raddr;
    logic [DATA_W-1:0] main_wdata, main_rdata;
    logic              helper_we, helper_re;
    logic [AW-1:0]     helper_waddr, helper_raddr;
    logic [DATA_W-1:0] helper_wdata, helper_rdata;

    logic          s_fire;
    logic          out_free;
    logic          move_back;
    logic          emit_last;
    logic [CW-1:0] cnt_dec, aux_dec, aux_dec2;

    tsis_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .re    (main_re),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    tsis_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_helper_ram (
        .aclk  (aclk),
        .we    (helper_we),
        .waddr (helper_waddr),
        .wdata (helper_wdata),
        .re    (helper_re),
        .raddr (helper_raddr),
        .rdata (helper_rdata)
    );

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cnt_dec   = cnt_reg - ONE_C;
    assign aux_dec   = aux_reg - ONE_C;
    assign aux_dec2  = aux_reg - TWO_C;
    assign move_back = (aux_reg != '0) && (top_reg > held_reg);
    assign emit_last = (idx_reg == aux_dec);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = ST_POP;
                end
            end
            ST_POP:  state_next = ST_HOLD;
            ST_HOLD: state_next = ST_PLACE;
            ST_PLACE: begin
                if (move_back) begin
                    state_next = (aux_reg >= TWO_C) ? ST_REFILL : ST_PLACE;
                end else begin
                    state_next = (cnt_reg != '0) ? ST_POP : ST_EMIT_RD;
                end
            end
            ST_REFILL:  state_next = ST_PLACE;
            ST_EMIT_RD: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (out_free) begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        aux_next     = aux_reg;
        idx_next     = idx_reg;
        ovf_next     = ovf_reg;
        held_next    = held_reg;
        top_next     = top_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        main_we      = 1'b0;
        main_waddr   = cnt_reg[AW-1:0];
        main_wdata   = s_tdata;
        main_re      = 1'b0;
        main_raddr   = cnt_dec[AW-1:0];
        helper_we    = 1'b0;
        helper_waddr = aux_reg[AW-1:0];
        helper_wdata = held_reg;
        helper_re    = 1'b0;
        helper_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (cnt_reg != DEPTH_C) begin
                        main_we  = 1'b1;
                        cnt_next = cnt_reg + ONE_C;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_POP: begin
                main_re  = 1'b1;
                cnt_next = cnt_dec;
            end
            ST_HOLD: begin
                held_next = main_rdata;
            end
            ST_PLACE: begin
                if (move_back) begin
                    main_we      = 1'b1;
                    main_wdata   = top_reg;
                    cnt_next     = cnt_reg + ONE_C;
                    aux_next     = aux_dec;
                    helper_re    = (aux_reg >= TWO_C);
                    helper_raddr = aux_dec2[AW-1:0];
                end else begin
                    helper_we = 1'b1;
                    top_next  = held_reg;
                    aux_next  = aux_reg + ONE_C;
                end
            end
            ST_REFILL: begin
                top_next = helper_rdata;
            end
            ST_EMIT_RD: begin
                helper_re = 1'b1;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = helper_rdata;
                    m_last_next  = emit_last;
                    m_user_next  = ovf_reg;
                    idx_next     = idx_reg + ONE_C;
                    if (emit_last) begin
                        idx_next = '0;
                        aux_next = '0;
                        ovf_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            aux_reg     <= '0;
            idx_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            aux_reg     <= aux_next;
            idx_reg     <= idx_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg   <= held_next;
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
